// ===== design/temp_buffer_pool_policy_defines.svh =====
// Assertion macros for the temporary buffer pool policy block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TEMP_BUFFER_POOL_POLICY_DEFINES_SVH
`define TEMP_BUFFER_POOL_POLICY_DEFINES_SVH

// Same-cycle implication.
`define TBPP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbpp assertion failed");

// Next-cycle implication.
`define TBPP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbpp assertion failed");

`endif

// ===== design/tbpp_pkg.sv =====
// Package for the temporary buffer pool policy: sizes, types and codes.
// No dependencies.
package tbpp_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SIZE_BITS = 32;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int ECNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [ECNT_W-1:0]    ecnt_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_REUSE = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // One list position: the slot it names and that slot's size.
  typedef struct packed {
    slot_t slot;
    size_t size;
  } entry_t;

  // Controls shared by every cell of the list.
  typedef struct packed {
    logic shift;
    logic sort_en;
  } cell_ctl_t;

  // True when entry a must stand before entry b.
  function automatic logic goes_before(entry_t a, logic a_use, entry_t b, logic b_use);
    if (a_use != b_use) return !a_use;
    return a.size < b.size;
  endfunction

endpackage

// ===== design/tbpp_cell.sv =====
// One list position of the pool order chain.
// Depends on tbpp_pkg.
module tbpp_cell (
  input  logic                clk_i,
  input  tbpp_pkg::cell_ctl_t ctl_i,
  input  logic                load_i,
  input  tbpp_pkg::entry_t    new_i,
  input  logic                pair_act_i,
  input  logic                left_swap_i,
  input  tbpp_pkg::entry_t    left_i,
  input  tbpp_pkg::entry_t    right_i,
  input  logic                in_use_i,
  input  logic                right_in_use_i,
  output tbpp_pkg::entry_t    entry_o,
  output logic                swap_o
);

  tbpp_pkg::entry_t entry_q, entry_d;

  // Exchange with the right neighbor only on a strict order violation.
  assign swap_o = ctl_i.sort_en && pair_act_i &&
                  tbpp_pkg::goes_before(right_i, right_in_use_i, entry_q, in_use_i);

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = new_i;
    end else if (ctl_i.shift || swap_o) begin
      entry_d = right_i;
    end else if (ctl_i.sort_en && left_swap_i) begin
      entry_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== design/temp_buffer_pool_policy.sv =====
// Temporary buffer pool policy: top level with handshake, slot flags and counters.
// Depends on tbpp_pkg, tbpp_cell and temp_buffer_pool_policy_defines.svh.
//
// Each request yields one result transaction. A free, a reused slot and a full pool
// resolve in the accept cycle, so the result is offered on the next cycle. An allocate
// that opens a new slot goes through S_SORT, where the list of cells runs MAX_SLOTS
// odd-even exchange phases to re-sort, then through S_EVICT, which checks for eviction.
// The list is a chain of cells, one per position, each holding a slot number and
// size and swapping with its neighbor. A new request is taken while the previous
// result waits only if that result is being taken in the same cycle.
`include "temp_buffer_pool_policy_defines.svh"

module temp_buffer_pool_policy (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] size_bytes_i,
  input  logic [3:0]  handle_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  handle_out_o,
  output logic [31:0] granted_size_o,
  output logic        evict_valid_o,
  output logic [3:0]  evict_handle_o
);

  localparam int N = tbpp_pkg::MAX_SLOTS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SORT  = 2'd1;
  localparam logic [1:0] S_EVICT = 2'd2;

  logic [1:0] state_q, state_d;
  tbpp_pkg::slot_t phase_q, phase_d;
  tbpp_pkg::ecnt_t ecnt_q, ecnt_d;
  logic [tbpp_pkg::CNT_W-1:0] out_cnt_q, out_cnt_d, peak_q, peak_d;
  logic [N-1:0] occ_q, occ_d, inuse_q, inuse_d;
  tbpp_pkg::slot_t new_slot_q, new_slot_d;
  tbpp_pkg::size_t new_size_q, new_size_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [3:0]  hout_q, hout_d, ev_h_q, ev_h_d;
  logic [31:0] gsize_q, gsize_d;
  logic        ev_v_q, ev_v_d;

  tbpp_pkg::entry_t    cell_e [N];
  logic [N-1:0]        cell_use, swap, load_vec, pair_act;
  tbpp_pkg::cell_ctl_t ctl;
  tbpp_pkg::entry_t    new_entry;

  logic            accept;
  tbpp_pkg::size_t req;
  logic            hit;
  tbpp_pkg::slot_t hit_slot, free_slot;
  tbpp_pkg::size_t hit_size;
  logic            have_free;
  logic [7:0]      h_ext;
  logic            bad_h;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign req        = tbpp_pkg::size_t'(size_bytes_i);
  assign new_entry  = '{slot: free_slot, size: req};

  // Per-position in-use flag and the active exchange pairs of this phase.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_use[i] = inuse_q[cell_e[i].slot];
      pair_act[i] = (i < N - 1) && (1'(i) == phase_q[0]) &&
                    (8'(i + 1) < 8'(ecnt_q));
    end
  end

  // First fitting unused entry in list order; lowest unoccupied slot.
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    hit_size = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if ((8'(i) < 8'(ecnt_q)) && !cell_use[i] && (cell_e[i].size >= req)) begin
        hit = 1'b1;
        hit_slot = cell_e[i].slot;
        hit_size = cell_e[i].size;
      end
    end
    have_free = 1'b0;
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!occ_q[i]) begin
        have_free = 1'b1;
        free_slot = tbpp_pkg::slot_t'(i);
      end
    end
  end

  assign h_ext = 8'(handle_in_i);
  assign bad_h = (h_ext >= 8'(N)) || !occ_q[h_ext[tbpp_pkg::SLOT_W-1:0]];

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ecnt_d = ecnt_q;
    out_cnt_d = out_cnt_q;
    peak_d = peak_q;
    occ_d = occ_q;
    inuse_d = inuse_q;
    new_slot_d = new_slot_q;
    new_size_d = new_size_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q;
    hout_d = hout_q;
    gsize_d = gsize_q;
    ev_v_d = ev_v_q;
    ev_h_d = ev_h_q;
    load_vec = '0;
    ctl = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ev_v_d = 1'b0;
          ev_h_d = '0;
          out_valid_d = 1'b1;
          if (req_type_i == tbpp_pkg::REQ_ALLOC) begin
            // Count the allocate and track the peak before the search.
            if (out_cnt_q < tbpp_pkg::COUNT_MAX) out_cnt_d = out_cnt_q + 1'b1;
            peak_d = (out_cnt_d > peak_q) ? out_cnt_d : peak_q;
            if (hit) begin
              inuse_d[hit_slot] = 1'b1;
              status_d = tbpp_pkg::ST_REUSE;
              hout_d = 4'(hit_slot);
              gsize_d = 32'(hit_size);
            end else if (!have_free || (8'(ecnt_q) >= 8'(N))) begin
              status_d = tbpp_pkg::ST_FULL;
              hout_d = '0;
              gsize_d = '0;
            end else begin
              // Open the slot, append it and start the re-sort.
              occ_d[free_slot] = 1'b1;
              inuse_d[free_slot] = 1'b1;
              load_vec[ecnt_q[tbpp_pkg::SLOT_W-1:0]] = 1'b1;
              ecnt_d = ecnt_q + 1'b1;
              new_slot_d = free_slot;
              new_size_d = req;
              phase_d = '0;
              out_valid_d = 1'b0;
              state_d = S_SORT;
            end
          end else begin
            hout_d = handle_in_i;
            gsize_d = '0;
            if (bad_h) begin
              status_d = tbpp_pkg::ST_BAD;
            end else begin
              inuse_d[h_ext[tbpp_pkg::SLOT_W-1:0]] = 1'b0;
              if (out_cnt_q != '0) out_cnt_d = out_cnt_q - 1'b1;
              status_d = tbpp_pkg::ST_REUSE;
            end
          end
        end
      end
      S_SORT: begin
        ctl.sort_en = 1'b1;
        phase_d = phase_q + 1'b1;
        if (phase_q == tbpp_pkg::slot_t'(N - 1)) state_d = S_EVICT;
      end
      S_EVICT: begin
        status_d = tbpp_pkg::ST_NEW;
        hout_d = 4'(new_slot_q);
        gsize_d = 32'(new_size_q);
        // Drop the head entry when the list outgrows the peak and it is unused.
        if ((8'(ecnt_q) > 8'(peak_q)) && !cell_use[0]) begin
          ctl.shift = 1'b1;
          ecnt_d = ecnt_q - 1'b1;
          occ_d[cell_e[0].slot] = 1'b0;
          ev_v_d = 1'b1;
          ev_h_d = 4'(cell_e[0].slot);
        end
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    tbpp_cell u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .load_i         (load_vec[g]),
      .new_i          (new_entry),
      .pair_act_i     (pair_act[g]),
      .left_swap_i    ((g > 0) ? swap[(g > 0) ? g - 1 : 0] : 1'b0),
      .left_i         (cell_e[(g > 0) ? g - 1 : 0]),
      .right_i        (cell_e[(g < N - 1) ? g + 1 : g]),
      .in_use_i       (cell_use[g]),
      .right_in_use_i (cell_use[(g < N - 1) ? g + 1 : g]),
      .entry_o        (cell_e[g]),
      .swap_o         (swap[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      ecnt_q <= '0;
      out_cnt_q <= '0;
      peak_q <= '0;
      occ_q <= '0;
      inuse_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ecnt_q <= ecnt_d;
      out_cnt_q <= out_cnt_d;
      peak_q <= peak_d;
      occ_q <= occ_d;
      inuse_q <= inuse_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_slot_q <= new_slot_d;
    new_size_q <= new_size_d;
    status_q <= status_d;
    hout_q <= hout_d;
    gsize_q <= gsize_d;
    ev_v_q <= ev_v_d;
    ev_h_q <= ev_h_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign handle_out_o   = hout_q;
  assign granted_size_o = gsize_q;
  assign evict_valid_o  = ev_v_q;
  assign evict_handle_o = ev_h_q;

  `TBPP_ASSERT_IMP(a_occ_matches_count, 1'b1, $countones(occ_q) == 32'(ecnt_q))
  `TBPP_ASSERT_IMP(a_evict_only_new, out_valid_o && evict_valid_o, status_o == tbpp_pkg::ST_NEW)
  `TBPP_ASSERT_IMP(a_no_result_in_sort, state_q == S_SORT, !out_valid_o)
  `TBPP_ASSERT_NXT(a_sort_follows_load, state_q == S_IDLE && (|load_vec), state_q == S_SORT)

endmodule
